// ----- hw/rtl/swmac_pkg.sv -----
// Package for the sliding-window median and absolute-deviation cost block.
// Holds the fixed port widths and the operation bundle shared by the cells and the top level.
// Depends on nothing.
package swmac_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 32;
    localparam int COST_W   = 40;
    localparam int CFG_W    = 9;

    typedef struct packed {
        logic remove;
        logic insert;
    } t_cell_op;

endpackage

// ----- hw/rtl/swmac_cell.sv -----
// One cell of the sorted chain: holds a single window value in ascending position.
// Shifts left on removal and right on insertion, trading values with its two neighbours.
// Depends on swmac_pkg.
module swmac_cell #(
    parameter int VAL_W = 32,
    parameter int CW    = 9,
    parameter int IDX   = 0
) (
    input  logic                  i_clk,
    input  swmac_pkg::t_cell_op   i_op,
    input  logic [CW-1:0]         i_count,
    input  logic [VAL_W-1:0]      i_key,
    input  logic [VAL_W-1:0]      i_left_val,
    input  logic                  i_left_gt,
    input  logic [VAL_W-1:0]      i_right_val,
    output logic [VAL_W-1:0]      o_val,
    output logic                  o_gt
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic             held;
    logic             ge;
    logic             gt;

    assign held = MY_IDX < i_count;
    assign ge   = held && (r_val >= i_key);
    assign gt   = held && (r_val > i_key);

    always_comb begin
        n_val = r_val;
        if (i_op.remove && ge) begin
            n_val = i_right_val;
        end else if (i_op.insert) begin
            if (held && !gt) begin
                n_val = r_val;
            end else if (i_left_gt) begin
                n_val = i_left_val;
            end else if (MY_IDX <= i_count) begin
                n_val = i_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_gt  = gt;

endmodule

// ----- hw/rtl/sliding_window_median_abs_cost.sv -----
// A sample beat with a full window passes through removal in the cell chain, insertion in
// the cell chain and the result load; while the window fills, removal is skipped. A result
// is produced only once the window is full, and a result still held at the output stalls the
// result load. A new sample is taken only while idle or in the result load of the last one.
// Reset is synchronous and active low; it clears the fill, the sums and the pointer and sets
// the window size to one. The stores need no clearing pass.
module sliding_window_median_abs_cost #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [swmac_pkg::CFG_W-1:0]     i_cfg_window_size,
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  logic [swmac_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [swmac_pkg::MEDIAN_W-1:0]  o_median,
    output logic [swmac_pkg::COST_W-1:0]    o_cost
);

    localparam int VAL_W = (SAMPLE_BITS < swmac_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                : swmac_pkg::SAMPLE_W;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW    = (CW > swmac_pkg::CFG_W) ? CW : swmac_pkg::CFG_W;
    localparam int SW    = swmac_pkg::COST_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_INSERT = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [swmac_pkg::CFG_W-1:0]   r_window;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 n_ptr;
    logic [SW-1:0]                 r_lower;
    logic [SW-1:0]                 n_lower;
    logic [SW-1:0]                 r_total;
    logic [SW-1:0]                 n_total;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [VAL_W-1:0]              r_sample;
    logic                          r_steady;
    logic [VAL_W-1:0]              r_rdata;
    logic [swmac_pkg::MEDIAN_W-1:0] r_median;
    logic [SW-1:0]                 r_cost;
    logic [VAL_W-1:0]              r_ring [WINDOW_MAX];

    logic [KW-1:0]                 ws_ext;
    logic [CW-1:0]                 k;
    logic [CW-1:0]                 lc;
    logic                          k_odd;
    logic                          cfg_acc;
    logic                          in_acc;
    logic                          full;
    logic                          out_free;
    logic                          finish_go;
    logic                          load_out;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 ptr_inc;

    swmac_pkg::t_cell_op           cell_op;
    logic [VAL_W-1:0]              cell_key;
    logic [VAL_W-1:0]              cell_val [WINDOW_MAX];
    logic                          cell_gt  [WINDOW_MAX];
    logic [VAL_W-1:0]              med_part [WINDOW_MAX];
    logic [VAL_W-1:0]              up_part  [WINDOW_MAX];
    logic [VAL_W-1:0]              med;
    logic [VAL_W-1:0]              up;
    logic                          med_held;
    logic                          up_held;
    logic [SW-1:0]                 med_ext;
    logic [SW-1:0]                 up_ext;
    logic [SW-1:0]                 rd_ext;
    logic [SW-1:0]                 smp_ext;

    assign ws_ext = KW'(r_window);
    always_comb begin
        if (ws_ext == '0) begin
            k = CW'(1);
        end else if (ws_ext > KW'(WINDOW_MAX)) begin
            k = CW'(WINDOW_MAX);
        end else begin
            k = CW'(ws_ext);
        end
    end
    assign lc    = CW'(({1'b0, k} + (CW+1)'(1)) >> 1);
    assign k_odd = k[0];

    assign cfg_acc        = i_cfg_valid && o_cfg_ready;
    assign in_acc         = i_sample_valid && o_sample_ready;
    assign full           = (r_count == k);
    assign out_free       = !r_out_valid || i_result_ready;
    assign finish_go      = (r_state == S_FINISH) && (!full || out_free);
    assign load_out       = finish_go && full;
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_sample_ready = ((r_state == S_IDLE) && !i_cfg_valid) || finish_go;

    assign cell_op.remove = (r_state == S_REMOVE);
    assign cell_op.insert = (r_state == S_INSERT);
    assign cell_key       = (r_state == S_REMOVE) ? r_rdata : r_sample;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic             left_gt;
        logic [VAL_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_inner
            assign left_val = cell_val[g-1];
            assign left_gt  = cell_gt[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_body
            assign right_val = cell_val[g+1];
        end

        swmac_cell #(
            .VAL_W (VAL_W),
            .CW    (CW),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_count     (r_count),
            .i_key       (cell_key),
            .i_left_val  (left_val),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .o_val       (cell_val[g]),
            .o_gt        (cell_gt[g])
        );

        assign med_part[g] = ((CW+1)'(g + 1) == {1'b0, lc}) ? cell_val[g] : '0;
        assign up_part[g]  = ((CW+1)'(g) == {1'b0, lc}) ? cell_val[g] : '0;
    end

    always_comb begin
        med = '0;
        up  = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            med = med | med_part[j];
            up  = up | up_part[j];
        end
    end

    assign med_held = lc <= r_count;
    assign up_held  = lc < r_count;
    assign med_ext  = SW'(med);
    assign up_ext   = up_held ? SW'(up) : '0;
    assign rd_ext   = SW'(r_rdata);
    assign smp_ext  = SW'(r_sample);
    assign ptr_inc  = r_ptr + AW'(1);
    assign wr_addr  = r_steady ? r_ptr : r_count[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_lower     = r_lower;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_result_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = full ? S_REMOVE : S_INSERT;
                end
            end
            S_REMOVE: begin
                n_state = S_INSERT;
                n_count = r_count - CW'(1);
                n_total = r_total - rd_ext;
                if (med_held && (med >= r_rdata)) begin
                    n_lower = r_lower - rd_ext + up_ext;
                end
            end
            S_INSERT: begin
                n_state = S_FINISH;
                n_count = r_count + CW'(1);
                n_total = r_total + smp_ext;
                if (!med_held || (med > r_sample)) begin
                    n_lower = r_lower + smp_ext - (med_held ? med_ext : '0);
                end
                if (r_steady) begin
                    n_ptr = ({1'b0, ptr_inc} == (AW+1)'(k)) ? '0 : ptr_inc;
                end
            end
            S_FINISH: begin
                if (finish_go) begin
                    if (in_acc) begin
                        n_state = full ? S_REMOVE : S_INSERT;
                    end else begin
                        n_state = S_IDLE;
                    end
                    if (load_out) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= swmac_pkg::CFG_W'(1);
            r_count     <= '0;
            r_ptr       <= '0;
            r_lower     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_acc) begin
                r_window <= i_cfg_window_size;
                r_count  <= '0;
                r_ptr    <= '0;
                r_lower  <= '0;
                r_total  <= '0;
            end else begin
                r_count <= n_count;
                r_ptr   <= n_ptr;
                r_lower <= n_lower;
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample[VAL_W-1:0];
            r_steady <= full;
        end
        if (load_out) begin
            r_median <= swmac_pkg::MEDIAN_W'(med);
            r_cost   <= r_total - (r_lower << 1) + (k_odd ? med_ext : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_INSERT) begin
            r_ring[wr_addr] <= r_sample;
        end
        r_rdata <= r_ring[r_ptr];
    end

    assign o_result_valid = r_out_valid;
    assign o_median       = r_median;
    assign o_cost         = r_cost;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= k)
        else $error("Fill count exceeds the window size.");

    a_ptr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW+1)'(r_ptr) < (AW+1)'(k))
        else $error("Ring pointer lies outside the window.");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |=> (r_count == CW'($past(r_count) - CW'(1))))
        else $error("Removal did not shrink the sorted chain by one.");

    a_result_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> (r_count == k))
        else $error("A result beat was raised with a partly filled window.");

endmodule
